### hdl/cstx_pkg.sv
// Shared types and constants for the CSMA/CD transmit sequencer.
// No dependencies; the top level and the checker refer to this package.
package cstx_pkg;

	localparam int unsigned CntW   = 16;
	localparam int unsigned PosW   = 10;
	localparam int unsigned RetryW = 4;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_IDLE_GAP    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FRAME       = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_WINDOW      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_JAM         = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SLOT        = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT = 3'd5;

	// reset values of the registers
	localparam logic [9:0]  IDLE_GAP_RST    = 10'd96;
	localparam logic [15:0] FRAME_RST       = 16'd576;
	localparam logic [9:0]  WINDOW_RST      = 10'd100;
	localparam logic [10:0] JAM_RST         = 11'd148;
	localparam logic [9:0]  SLOT_RST        = 10'd512;
	localparam logic [3:0]  RETRY_LIMIT_RST = 4'd10;

	// phase codes as seen on the result beat
	localparam logic [2:0] PH_DEFER   = 3'd0;
	localparam logic [2:0] PH_SEND    = 3'd1;
	localparam logic [2:0] PH_RELEASE = 3'd2;
	localparam logic [2:0] PH_JAM     = 3'd3;
	localparam logic [2:0] PH_BACKOFF = 3'd4;

	// event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_SENT = 2'd1;
	localparam logic [1:0] EV_COLL = 2'd2;
	localparam logic [1:0] EV_DROP = 2'd3;

	localparam logic [RetryW-1:0] RETRY_MAX = 4'd15;

	typedef enum logic [4:0] {
		ST_DEFER   = 5'b00001,
		ST_SEND    = 5'b00010,
		ST_RELEASE = 5'b00100,
		ST_JAM     = 5'b01000,
		ST_BACKOFF = 5'b10000
	} state_t;

	function automatic logic [2:0] phase_code(input state_t st);
		logic [2:0] code;
		unique case (st)
			ST_DEFER:   code = PH_DEFER;
			ST_SEND:    code = PH_SEND;
			ST_RELEASE: code = PH_RELEASE;
			ST_JAM:     code = PH_JAM;
			ST_BACKOFF: code = PH_BACKOFF;
			default:    code = PH_DEFER;
		endcase
		return code;
	endfunction

endpackage

### hdl/cstx_tick_if.sv
// Input channel: one beat per bit time on the line.
// Depends on nothing.
interface cstx_tick_if;
	logic       valid;
	logic       ready;
	logic       line_busy;
	logic       collision;
	logic [1:0] random_draw;

	modport source (output valid, line_busy, collision, random_draw, input ready);
	modport sink   (input valid, line_busy, collision, random_draw, output ready);
endinterface

### hdl/cstx_result_if.sv
// Result channel: phase, event and retry count for each bit time.
// Depends on nothing.
interface cstx_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase;
	logic [1:0] event_res;
	logic [3:0] retries;

	modport source (output valid, phase, event_res, retries, input ready);
	modport sink   (input valid, phase, event_res, retries, output ready);
endinterface

### hdl/csma_cd_transmit_sequencer.sv
// CSMA/CD transmit sequencer top level: defer, send, release, jam, backoff.
// Depends on cstx_pkg, cstx_tick_if and cstx_result_if.
//
//   channel   dir   beat contents                          handshake
//   tick      in    line_busy, collision, random_draw      valid/ready
//   result    out   phase, event_res, retries              valid/ready
//   cfg       in    cfg_index, cfg_data                    cfg_wr_en, no wait
//
// One beat per cycle while the result side keeps up: state updates on the accepted
// tick and the result lands in the output register on the same edge.
// tick.ready stays high unless a result is held and result.ready is low.
// arst_n clears the state, the registers to their defaults, and the result valid.
module csma_cd_transmit_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	cstx_tick_if.sink                          tick,
	cstx_result_if.source                      result,
	input  logic                               cfg_wr_en,
	input  logic [cstx_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [cstx_pkg::CfgDataW-1:0]      cfg_data
);

	logic [9:0]  idle_gap_q;
	logic [15:0] frame_q;
	logic [9:0]  window_q;
	logic [10:0] jam_q;
	logic [9:0]  slot_q;
	logic [3:0]  retry_limit_q;

	cstx_pkg::state_t                  state_q, state_d;
	logic [cstx_pkg::CntW-1:0]         cnt_q, cnt_d;
	logic [cstx_pkg::PosW-1:0]         pos_q, pos_d;
	logic [cstx_pkg::RetryW-1:0]       retry_q, retry_d;
	logic                              over_q, over_d;
	logic [1:0]                        ev_d;

	logic                              out_valid_q;
	logic [2:0]                        phase_q;
	logic [1:0]                        event_q;
	logic [3:0]                        retries_q;

	logic        accept;
	logic        cnt_last;
	logic        in_window;
	logic [11:0] backoff_len;

	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_gap_q    <= cstx_pkg::IDLE_GAP_RST;
			frame_q       <= cstx_pkg::FRAME_RST;
			window_q      <= cstx_pkg::WINDOW_RST;
			jam_q         <= cstx_pkg::JAM_RST;
			slot_q        <= cstx_pkg::SLOT_RST;
			retry_limit_q <= cstx_pkg::RETRY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cstx_pkg::REG_IDLE_GAP:    idle_gap_q    <= cfg_data[9:0];
				cstx_pkg::REG_FRAME:       frame_q       <= cfg_data[15:0];
				cstx_pkg::REG_WINDOW:      window_q      <= cfg_data[9:0];
				cstx_pkg::REG_JAM:         jam_q         <= cfg_data[10:0];
				cstx_pkg::REG_SLOT:        slot_q        <= cfg_data[9:0];
				cstx_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cnt_last    = (cnt_q <= 16'd1);
	assign in_window   = (pos_q < window_q);
	assign backoff_len = {10'd0, tick.random_draw} * {2'd0, slot_q};

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		retry_d = retry_q;
		over_d  = over_q;
		ev_d    = cstx_pkg::EV_NONE;
		unique case (state_q)
			cstx_pkg::ST_DEFER: begin
				if (tick.line_busy) begin
					cnt_d = {6'd0, idle_gap_q};
				end else if (cnt_last) begin
					state_d = cstx_pkg::ST_SEND;
					cnt_d   = frame_q;
					pos_d   = '0;
				end else begin
					cnt_d = cnt_q - 16'd1;
				end
			end
			cstx_pkg::ST_SEND: begin
				if (in_window && tick.collision) begin
					ev_d    = cstx_pkg::EV_COLL;
					over_d  = ({1'b0, retry_q} + 5'd1) > {1'b0, retry_limit_q};
					if (retry_q != cstx_pkg::RETRY_MAX)
						retry_d = retry_q + 4'd1;
					state_d = cstx_pkg::ST_JAM;
					cnt_d   = {5'd0, jam_q};
				end else begin
					if (in_window)
						pos_d = pos_q + 10'd1;
					if (cnt_last) begin
						state_d = cstx_pkg::ST_RELEASE;
						cnt_d   = {6'd0, window_q};
					end else begin
						cnt_d = cnt_q - 16'd1;
					end
				end
			end
			cstx_pkg::ST_RELEASE: begin
				if (cnt_last) begin
					ev_d    = cstx_pkg::EV_SENT;
					retry_d = '0;
					over_d  = 1'b0;
					state_d = cstx_pkg::ST_DEFER;
					cnt_d   = {6'd0, idle_gap_q};
				end else begin
					cnt_d = cnt_q - 16'd1;
				end
			end
			cstx_pkg::ST_JAM: begin
				if (cnt_last) begin
					if (over_q) begin
						// drop the frame and start over with a clean count
						ev_d    = cstx_pkg::EV_DROP;
						retry_d = '0;
						over_d  = 1'b0;
						state_d = cstx_pkg::ST_DEFER;
						cnt_d   = {6'd0, idle_gap_q};
					end else if (backoff_len == 12'd0) begin
						state_d = cstx_pkg::ST_DEFER;
						cnt_d   = {6'd0, idle_gap_q};
					end else begin
						state_d = cstx_pkg::ST_BACKOFF;
						cnt_d   = {4'd0, backoff_len};
					end
				end else begin
					cnt_d = cnt_q - 16'd1;
				end
			end
			cstx_pkg::ST_BACKOFF: begin
				if (cnt_last) begin
					state_d = cstx_pkg::ST_DEFER;
					cnt_d   = {6'd0, idle_gap_q};
				end else begin
					cnt_d = cnt_q - 16'd1;
				end
			end
			default: begin
				state_d = cstx_pkg::ST_DEFER;
				cnt_d   = {6'd0, idle_gap_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cstx_pkg::ST_DEFER;
			cnt_q   <= {6'd0, cstx_pkg::IDLE_GAP_RST};
			pos_q   <= '0;
			retry_q <= '0;
			over_q  <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			retry_q <= retry_d;
			over_q  <= over_d;
		end
	end

	// result register: load on every accepted tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q   <= cstx_pkg::phase_code(state_q);
			event_q   <= ev_d;
			retries_q <= retry_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.phase     = phase_q;
	assign result.event_res = event_q;
	assign result.retries   = retries_q;

endmodule

### hdl/cstx_checker.sv
// Port-level checks for the CSMA/CD transmit sequencer, bound to the top level.
// Depends on cstx_pkg and csma_cd_transmit_sequencer.
module cstx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tick_valid,
	input logic       tick_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_phase,
	input logic [1:0] res_event,
	input logic [3:0] res_retries
);

	// a held result stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// every accepted tick shows up as a result on the next cycle
	a_tick_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> res_valid)
		else $error("accepted tick produced no result");

	// an empty output side never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> tick_ready)
		else $error("input stalled with no result pending");

	// each event comes from the phase that can raise it
	a_event_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			(res_event == cstx_pkg::EV_NONE) ||
			(res_event == cstx_pkg::EV_SENT && res_phase == cstx_pkg::PH_RELEASE) ||
			(res_event == cstx_pkg::EV_COLL && res_phase == cstx_pkg::PH_SEND) ||
			(res_event == cstx_pkg::EV_DROP && res_phase == cstx_pkg::PH_JAM))
		else $error("event raised in the wrong phase");

	// a sent or dropped frame clears the retry count; a collision counts one
	a_retry_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			((res_event != cstx_pkg::EV_SENT && res_event != cstx_pkg::EV_DROP) ||
				res_retries == 4'd0) &&
			(res_event != cstx_pkg::EV_COLL || res_retries != 4'd0))
		else $error("retry count inconsistent with event");

endmodule

bind csma_cd_transmit_sequencer cstx_checker u_cstx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_valid  (tick.valid),
	.tick_ready  (tick.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_phase   (result.phase),
	.res_event   (result.event_res),
	.res_retries (result.retries)
);
